[src/kpd_pkg.sv]
// ----------------------------------------------------------------------------
// kpd_pkg
// Shared types and constants of the 4x4 debounced matrix keypad scanner.
// ----------------------------------------------------------------------------
package kpd_pkg;

   localparam int NUM_ROWS = 4;
   localparam int NUM_COLS = 4;
   localparam int NUM_KEYS = NUM_ROWS * NUM_COLS;

   localparam int ROW_W   = $clog2(NUM_ROWS);
   localparam int COL_W   = $clog2(NUM_COLS);
   localparam int KEY_W   = ROW_W + COL_W;
   localparam int CODE_W  = 8;
   localparam int TICK_W  = 8;
   localparam int MAP_W   = NUM_COLS * CODE_W;
   localparam int CSR_IDX_W = 3;

   // register indexes of the control port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEBOUNCE_TICKS = 3'd0,
      CSR_KEY_MAP_ROW0   = 3'd1,
      CSR_KEY_MAP_ROW1   = 3'd2,
      CSR_KEY_MAP_ROW2   = 3'd3,
      CSR_KEY_MAP_ROW3   = 3'd4
   } csr_index_type;

   // reset values: "123A", "456B", "789C", "*0#D", column 0 in the low byte
   localparam logic [TICK_W-1:0] DEBOUNCE_RESET = 8'd15;
   localparam logic [MAP_W-1:0]  KEY_MAP_ROW0_RESET = 32'h4133_3231;
   localparam logic [MAP_W-1:0]  KEY_MAP_ROW1_RESET = 32'h4236_3534;
   localparam logic [MAP_W-1:0]  KEY_MAP_ROW2_RESET = 32'h4339_3837;
   localparam logic [MAP_W-1:0]  KEY_MAP_ROW3_RESET = 32'h4423_302A;

   typedef struct packed {
      logic [TICK_W-1:0]               debounce_ticks;
      logic [NUM_ROWS-1:0][MAP_W-1:0]  key_map;
   } kpd_cfg_type;

   typedef struct packed {
      logic [NUM_ROWS-1:0] row_drive;
      logic                key_valid;
      logic [CODE_W-1:0]   key_code;
      logic                scan_done;
   } kpd_result_type;

endpackage

[src/kpd_channels.sv]
// ----------------------------------------------------------------------------
// kpd channel interfaces
// Valid/ready channels for column samples, scan results and register writes.
// ----------------------------------------------------------------------------
interface kpd_req_if;
   logic       valid;
   logic       ready;
   logic [3:0] column_levels;

   modport source (output valid, output column_levels, input ready);
   modport sink   (input valid, input column_levels, output ready);
endinterface

interface kpd_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] row_drive;
   logic       key_valid;
   logic [7:0] key_code;
   logic       scan_done;

   modport source (output valid, output row_drive, output key_valid,
                   output key_code, output scan_done, input ready);
   modport sink   (input valid, input row_drive, input key_valid,
                   input key_code, input scan_done, output ready);
endinterface

interface kpd_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[src/matrix_keypad_scanner.sv]
// ----------------------------------------------------------------------------
// matrix_keypad_scanner
// 4x4 debounced key matrix scanner: one result per tick of column samples.
// ----------------------------------------------------------------------------
//  channel   direction  payload                                       role
//  req_port  in         column_levels[3:0]                            one tick
//  rsp_port  out        row_drive[3:0] key_valid key_code[7:0]        one per tick
//                       scan_done
//  csr_port  in         index[2:0] data[31:0]                         register write
//
//  every tick passes the input register, then the scan update into the result
//  register before its result is shown; one tick per cycle sustained while
//  results are taken, set by the single scan state update
//  reset (synchronous) clears scan position, countdown and held marks and
//  loads the default debounce time and key map
//  a stalled result holds the scan; one further tick waits in the input register
// ----------------------------------------------------------------------------
module matrix_keypad_scanner
   import kpd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   kpd_req_if.sink   req_port,
   kpd_rsp_if.source rsp_port,
   kpd_csr_if.sink   csr_port
);

   kpd_cfg_type    cfg;
   kpd_result_type result;

   // input register
   logic       in_valid_ff;
   logic [3:0] levels_ff;

   // result register
   logic           out_valid_ff;
   kpd_result_type result_ff;

   logic advance;

   // the held tick moves on when the result register is free or being drained
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_port.ready);
   assign req_port.ready = !in_valid_ff || advance;

   kpd_csr_regs u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_port (csr_port),
      .cfg      (cfg)
   );

   kpd_scan_core u_core (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .column_levels (levels_ff),
      .cfg           (cfg),
      .result        (result)
   );

   // control flags of both stages
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_port.ready) begin
            in_valid_ff <= req_port.valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_port.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_port.valid && req_port.ready) begin
         levels_ff <= req_port.column_levels;
      end
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_port.valid     = out_valid_ff;
   assign rsp_port.row_drive = result_ff.row_drive;
   assign rsp_port.key_valid = result_ff.key_valid;
   assign rsp_port.key_code  = result_ff.key_code;
   assign rsp_port.scan_done = result_ff.scan_done;

endmodule

[src/kpd_csr_regs.sv]
// ----------------------------------------------------------------------------
// kpd_csr_regs
// Debounce time and key map registers, written over the control channel.
// ----------------------------------------------------------------------------
module kpd_csr_regs
   import kpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   kpd_csr_if.sink     csr_port,
   output kpd_cfg_type cfg
);

   kpd_cfg_type cfg_ff;
   kpd_cfg_type cfg_in;
   logic        wr_en;

   assign csr_port.ready = 1'b1;
   assign wr_en          = csr_port.valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_index_type'(csr_port.index))
            CSR_DEBOUNCE_TICKS: cfg_in.debounce_ticks = csr_port.data[TICK_W-1:0];
            CSR_KEY_MAP_ROW0:   cfg_in.key_map[0] = csr_port.data[MAP_W-1:0];
            CSR_KEY_MAP_ROW1:   cfg_in.key_map[1] = csr_port.data[MAP_W-1:0];
            CSR_KEY_MAP_ROW2:   cfg_in.key_map[2] = csr_port.data[MAP_W-1:0];
            CSR_KEY_MAP_ROW3:   cfg_in.key_map[3] = csr_port.data[MAP_W-1:0];
            default: ;  // unknown index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks <= DEBOUNCE_RESET;
         cfg_ff.key_map[0]     <= KEY_MAP_ROW0_RESET;
         cfg_ff.key_map[1]     <= KEY_MAP_ROW1_RESET;
         cfg_ff.key_map[2]     <= KEY_MAP_ROW2_RESET;
         cfg_ff.key_map[3]     <= KEY_MAP_ROW3_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[src/kpd_scan_core.sv]
// ----------------------------------------------------------------------------
// kpd_scan_core
// Scan position, debounce countdown and held-key marks; one tick per step.
// ----------------------------------------------------------------------------
module kpd_scan_core
   import kpd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  logic [3:0]     column_levels,
   input  kpd_cfg_type    cfg,
   output kpd_result_type result
);

   logic [ROW_W-1:0]    row_ff, row_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic                pending_ff, pending_in;
   logic [TICK_W-1:0]   wait_ff, wait_in;
   logic [NUM_KEYS-1:0] marks_ff, marks_in;

   logic             col_low;
   logic             have_verdict;
   logic             pressed;
   logic             held;
   logic [KEY_W-1:0] key_idx;

   assign col_low = ~column_levels[col_ff];
   assign key_idx = {row_ff, col_ff};
   assign held    = marks_ff[key_idx];

   always_comb begin
      row_in       = row_ff;
      col_in       = col_ff;
      pending_in   = pending_ff;
      wait_in      = wait_ff;
      marks_in     = marks_ff;
      have_verdict = 1'b0;
      pressed      = 1'b0;

      result.row_drive = ~(NUM_ROWS'(1) << row_ff);
      result.key_valid = 1'b0;
      result.key_code  = '0;
      result.scan_done = 1'b0;

      // debounce: first low sample starts the countdown, last tick decides
      if (pending_ff) begin
         if (wait_ff > TICK_W'(1)) begin
            wait_in = wait_ff - TICK_W'(1);
         end else begin
            wait_in      = '0;
            pending_in   = 1'b0;
            have_verdict = 1'b1;
            pressed      = col_low;
         end
      end else if (col_low) begin
         if (cfg.debounce_ticks == '0) begin
            have_verdict = 1'b1;
            pressed      = 1'b1;
         end else begin
            pending_in = 1'b1;
            wait_in    = cfg.debounce_ticks;
         end
      end else begin
         have_verdict = 1'b1;
      end

      if (have_verdict) begin
         if (pressed && !held) begin
            marks_in[key_idx] = 1'b1;
            result.key_valid  = 1'b1;
            result.key_code   = cfg.key_map[row_ff][col_ff*CODE_W +: CODE_W];
            row_in            = '0;
            col_in            = '0;
         end else begin
            if (!pressed) begin
               marks_in[key_idx] = 1'b0;
            end
            col_in = col_ff + COL_W'(1);
            if (col_ff == COL_W'(NUM_COLS-1)) begin
               row_in = row_ff + ROW_W'(1);
               if (row_ff == ROW_W'(NUM_ROWS-1)) begin
                  result.scan_done = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff     <= '0;
         col_ff     <= '0;
         pending_ff <= 1'b0;
         wait_ff    <= '0;
         marks_ff   <= '0;
      end else if (step) begin
         row_ff     <= row_in;
         col_ff     <= col_in;
         pending_ff <= pending_in;
         wait_ff    <= wait_in;
         marks_ff   <= marks_in;
      end
   end

   // a pending confirmation always has ticks left to count
   a_pending_count: assert property (@(posedge clock) disable iff (reset)
      pending_ff |-> wait_ff != '0)
      else $error("debounce pending with empty countdown");

   // a reported key restarts the scan at the first key
   a_restart: assert property (@(posedge clock) disable iff (reset)
      step && result.key_valid |=> row_ff == '0 && col_ff == '0)
      else $error("scan did not restart after a new key");

   // a reported key is marked as held
   a_mark_set: assert property (@(posedge clock) disable iff (reset)
      step && result.key_valid |=> marks_ff != '0)
      else $error("reported key not marked");

   // position holds while the countdown is still running
   a_hold_wait: assert property (@(posedge clock) disable iff (reset)
      step && pending_ff && wait_ff > TICK_W'(1) |=> $stable(row_ff) && $stable(col_ff))
      else $error("scan moved during debounce wait");

   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      step |-> !(result.key_valid && result.scan_done))
      else $error("new key and scan end flagged together");

endmodule
